// ----- hw/rtl/prioritized_time_source_keeper_defines.svh -----
// Assertion macros shared by the checker file of this block.
`ifndef PRIORITIZED_TIME_SOURCE_KEEPER_DEFINES_SVH
`define PRIORITIZED_TIME_SOURCE_KEEPER_DEFINES_SVH

// Checks that a property holds at every clock edge outside of reset.
`define PTSK_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ptsk assertion failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define PTSK_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
		else $error("ptsk assertion failed");

`endif

// ----- hw/rtl/ptsk_pkg.sv -----
package ptsk_pkg;

	localparam int ZONE_BYTES = 7;
	localparam int ZONE_W = 8 * ZONE_BYTES;
	localparam int TICK_W = 32;
	localparam int SEC_W = 32;
	localparam int OFF_W = 16;
	localparam int DATA_W = 32;
	localparam int PADDR_W = 3;

	localparam logic [1:0] OP_PHONE = 2'd0;
	localparam logic [1:0] OP_SAT = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_PHONE = 2'd1;
	localparam logic [1:0] SRC_SAT = 2'd2;

	localparam logic [0:0] REG_STALE_LIMIT = 1'b0;
	localparam logic [TICK_W-1:0] STALE_LIMIT_RST = 32'd3600000;

	// Division of a 32-bit millisecond count by 1000 is exact as
	// (x * ceil(2^41 / 1000)) >> 41.
	localparam int PROD_W = 2 * TICK_W;
	localparam int RECIP_SHIFT = 41;
	localparam int QUO_W = PROD_W - RECIP_SHIFT;
	localparam logic [TICK_W-1:0] RECIP = 32'd2199023256;

	typedef struct packed {
		logic [1:0] opcode;
		logic [TICK_W-1:0] now_tick;
		logic [SEC_W-1:0] utc_in;
		logic signed [OFF_W-1:0] offset_in;
		logic [ZONE_W-1:0] zone_in;
	} cmd_t;

	typedef struct packed {
		logic time_valid;
		logic [SEC_W-1:0] utc_out;
		logic source_out;
		logic offset_valid;
		logic signed [OFF_W-1:0] offset_out;
		logic [ZONE_W-1:0] zone_out;
	} rsp_t;

	// Keeps the bytes before the first zero byte and clears the rest.
	function automatic logic [ZONE_W-1:0] clean_zone(input logic [ZONE_W-1:0] raw);
		logic [ZONE_W-1:0] kept;
		logic live;
		kept = '0;
		live = 1'b1;
		for (int i = 0; i < ZONE_BYTES; i++) begin
			if (raw[8*i +: 8] == 8'h00) begin
				live = 1'b0;
			end
			if (live) begin
				kept[8*i +: 8] = raw[8*i +: 8];
			end
		end
		return kept;
	endfunction

endpackage

// ----- hw/rtl/ptsk_if.sv -----
interface ptsk_cmd_if;
	logic valid;
	logic ready;
	ptsk_pkg::cmd_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface ptsk_rsp_if;
	logic valid;
	logic ready;
	ptsk_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/prioritized_time_source_keeper.sv -----
// Time source keeper. Command words arrive on cmd (phone update, satellite update,
// read, clear) and one command word is taken per clock cycle when the pipeline is
// not stalled. Updates and clear change the kept state as they leave the input
// register, so a following word in the next cycle already sees them. A read returns
// one word on rsp after the freshness check on the input register, the reciprocal
// multiply that divides the elapsed milliseconds by 1000, and the final add into the
// output register, in that order. Updates and clear return no word.
// A stalled rsp holds the pipeline back one stage at a time, so new words are still
// taken until every stage is full. The stale limit is written over the APB port at
// byte address 0 and reads back there.
module prioritized_time_source_keeper (
	input logic clk,
	input logic arst_n,
	ptsk_cmd_if.sink cmd,
	ptsk_rsp_if.source rsp,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [ptsk_pkg::PADDR_W-1:0] paddr,
	input logic [ptsk_pkg::DATA_W-1:0] pwdata,
	output logic [ptsk_pkg::DATA_W-1:0] prdata,
	output logic pready
);

	logic [ptsk_pkg::TICK_W-1:0] stale_limit_q;
	logic [ptsk_pkg::SEC_W-1:0] anchor_sec_q;
	logic [ptsk_pkg::TICK_W-1:0] anchor_tick_q;
	logic [1:0] anchor_src_q;
	logic signed [ptsk_pkg::OFF_W-1:0] zone_off_q;
	logic zone_off_set_q;
	logic [ptsk_pkg::TICK_W-1:0] zone_off_tick_q;
	logic [ptsk_pkg::ZONE_W-1:0] zone_text_q;

	logic v_s1;
	ptsk_pkg::cmd_t cmd_s1;

	logic v_s2;
	logic time_ok_s2;
	logic off_ok_s2;
	logic [ptsk_pkg::TICK_W-1:0] elapsed_s2;
	logic [ptsk_pkg::SEC_W-1:0] anchor_s2;
	logic sat_s2;
	logic signed [ptsk_pkg::OFF_W-1:0] off_s2;
	logic [ptsk_pkg::ZONE_W-1:0] zone_s2;

	logic v_s3;
	logic time_ok_s3;
	logic off_ok_s3;
	logic [ptsk_pkg::QUO_W-1:0] quo_s3;
	logic [ptsk_pkg::SEC_W-1:0] anchor_s3;
	logic sat_s3;
	logic signed [ptsk_pkg::OFF_W-1:0] off_s3;
	logic [ptsk_pkg::ZONE_W-1:0] zone_s3;

	logic rsp_valid_q;
	ptsk_pkg::rsp_t rsp_q;

	logic rdy_o;
	logic rdy_s3;
	logic rdy_s2;
	logic go_s1;
	logic go_s2;
	logic go_s3;
	logic is_read_s1;
	logic [ptsk_pkg::TICK_W-1:0] elapsed;
	logic [ptsk_pkg::TICK_W-1:0] off_age;
	logic anc_fresh;
	logic off_fresh;
	logic time_ok;
	logic off_ok;
	logic keep_sat;
	logic [ptsk_pkg::PROD_W-1:0] prod;
	logic [ptsk_pkg::SEC_W-1:0] utc_sum;
	logic cfg_wr;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[ptsk_pkg::PADDR_W-1:2] == ptsk_pkg::REG_STALE_LIMIT);
	assign prdata = (paddr[ptsk_pkg::PADDR_W-1:2] == ptsk_pkg::REG_STALE_LIMIT)
		? stale_limit_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stale_limit_q <= ptsk_pkg::STALE_LIMIT_RST;
		end else if (cfg_wr) begin
			stale_limit_q <= pwdata;
		end
	end

	// Handshake chain from the output back to the input register.
	assign rdy_o = !rsp_valid_q || rsp.ready;
	assign rdy_s3 = !v_s3 || rdy_o;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign is_read_s1 = (cmd_s1.opcode == ptsk_pkg::OP_READ);
	assign go_s1 = v_s1 && (!is_read_s1 || rdy_s2);
	assign go_s2 = v_s2 && rdy_s3;
	assign go_s3 = v_s3 && rdy_o;
	assign cmd.ready = !v_s1 || go_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.ready) begin
				v_s1 <= cmd.valid;
			end
			if (rdy_s2) begin
				v_s2 <= go_s1 && is_read_s1;
			end
			if (rdy_s3) begin
				v_s3 <= go_s2;
			end
			if (rdy_o) begin
				rsp_valid_q <= go_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.payload;
		end
	end

	// Freshness of the kept anchor and offset against the word in stage one.
	assign elapsed = cmd_s1.now_tick - anchor_tick_q;
	assign off_age = cmd_s1.now_tick - zone_off_tick_q;
	assign anc_fresh = elapsed < stale_limit_q;
	assign off_fresh = off_age < stale_limit_q;
	assign time_ok = (anchor_src_q != ptsk_pkg::SRC_NONE) && anc_fresh;
	assign off_ok = time_ok && zone_off_set_q && off_fresh;
	assign keep_sat = (anchor_src_q == ptsk_pkg::SRC_SAT) && anc_fresh;

	// Control part of the kept state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_src_q <= ptsk_pkg::SRC_NONE;
			zone_off_set_q <= 1'b0;
		end else if (go_s1) begin
			case (cmd_s1.opcode)
				ptsk_pkg::OP_PHONE: begin
					zone_off_set_q <= 1'b1;
					if (!keep_sat) begin
						anchor_src_q <= ptsk_pkg::SRC_PHONE;
					end
				end
				ptsk_pkg::OP_SAT: begin
					anchor_src_q <= ptsk_pkg::SRC_SAT;
				end
				ptsk_pkg::OP_CLEAR: begin
					anchor_src_q <= ptsk_pkg::SRC_NONE;
					zone_off_set_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// Data part of the kept state; its values only reach a response while its control bits say so.
	always_ff @(posedge clk) begin
		if (go_s1) begin
			case (cmd_s1.opcode)
				ptsk_pkg::OP_PHONE: begin
					zone_off_q <= cmd_s1.offset_in;
					zone_off_tick_q <= cmd_s1.now_tick;
					zone_text_q <= ptsk_pkg::clean_zone(cmd_s1.zone_in);
					if (!keep_sat) begin
						anchor_sec_q <= cmd_s1.utc_in;
						anchor_tick_q <= cmd_s1.now_tick;
					end
				end
				ptsk_pkg::OP_SAT: begin
					anchor_sec_q <= cmd_s1.utc_in;
					anchor_tick_q <= cmd_s1.now_tick;
				end
				default: begin
				end
			endcase
		end
	end

	// Stage two: snapshot of what a read needs.
	always_ff @(posedge clk) begin
		if (rdy_s2 && go_s1 && is_read_s1) begin
			time_ok_s2 <= time_ok;
			off_ok_s2 <= off_ok;
			elapsed_s2 <= elapsed;
			anchor_s2 <= anchor_sec_q;
			sat_s2 <= (anchor_src_q == ptsk_pkg::SRC_SAT);
			off_s2 <= zone_off_q;
			zone_s2 <= zone_text_q;
		end
	end

	// Stage three: elapsed milliseconds divided by 1000.
	assign prod = {{(ptsk_pkg::PROD_W-ptsk_pkg::TICK_W){1'b0}}, elapsed_s2}
		* {{(ptsk_pkg::PROD_W-ptsk_pkg::TICK_W){1'b0}}, ptsk_pkg::RECIP};

	always_ff @(posedge clk) begin
		if (go_s2) begin
			time_ok_s3 <= time_ok_s2;
			off_ok_s3 <= off_ok_s2;
			quo_s3 <= prod[ptsk_pkg::PROD_W-1:ptsk_pkg::RECIP_SHIFT];
			anchor_s3 <= anchor_s2;
			sat_s3 <= sat_s2;
			off_s3 <= off_s2;
			zone_s3 <= zone_s2;
		end
	end

	// Output register.
	assign utc_sum = anchor_s3
		+ {{(ptsk_pkg::SEC_W-ptsk_pkg::QUO_W){1'b0}}, quo_s3};

	always_ff @(posedge clk) begin
		if (go_s3) begin
			rsp_q.time_valid <= time_ok_s3;
			rsp_q.utc_out <= time_ok_s3 ? utc_sum : '0;
			rsp_q.source_out <= time_ok_s3 && sat_s3;
			rsp_q.offset_valid <= off_ok_s3;
			rsp_q.offset_out <= off_ok_s3 ? off_s3 : '0;
			rsp_q.zone_out <= off_ok_s3 ? zone_s3 : '0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

endmodule

// ----- hw/rtl/ptsk_checker.sv -----
`include "prioritized_time_source_keeper_defines.svh"

module ptsk_checker (
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input ptsk_pkg::rsp_t rsp_payload
);

	logic rsp_stall;
	logic no_time_ok;
	logic no_off_ok;
	logic [ptsk_pkg::ZONE_BYTES-2:0] zone_tail_ok;

	assign rsp_stall = rsp_valid && !rsp_ready;
	assign no_time_ok = !(rsp_valid && !rsp_payload.time_valid)
		|| (rsp_payload.utc_out == '0 && !rsp_payload.source_out
		&& !rsp_payload.offset_valid);
	assign no_off_ok = !(rsp_valid && !rsp_payload.offset_valid)
		|| (rsp_payload.offset_out == '0 && rsp_payload.zone_out == '0);

	for (genvar i = 0; i < ptsk_pkg::ZONE_BYTES - 1; i++) begin : g_zone
		assign zone_tail_ok[i] = !(rsp_valid && rsp_payload.zone_out[8*i +: 8] == 8'h00)
			|| (rsp_payload.zone_out[8*(i+1) +: 8] == 8'h00);
	end

	// A stalled result word keeps its value.
	`PTSK_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp_payload))

	// Without valid time the time, source and offset valid fields read as zero.
	`PTSK_ASSERT(a_no_time_zero, clk, arst_n, no_time_ok)

	// Without a valid offset the offset and zone read as zero.
	`PTSK_ASSERT(a_no_off_zero, clk, arst_n, no_off_ok)

	// The zone name never holds a byte after its end mark.
	`PTSK_ASSERT(a_zone_tail, clk, arst_n, &zone_tail_ok)

endmodule

bind prioritized_time_source_keeper ptsk_checker u_ptsk_checker (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.rsp_payload(rsp.payload)
);
